// ===== hw/rtl/ist_pkg.sv =====
// Shared types, constants and helpers for the stash table.
`default_nettype none

package ist_pkg;

  localparam int DEPTH       = 16;
  localparam int MAX_RESULTS = 16;
  localparam int IDX_W       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int NUM_W       = $clog2(MAX_RESULTS + 1);

  typedef enum logic [2:0] {
    OP_SET      = 3'd0,
    OP_GET      = 3'd1,
    OP_CLR_LOCO = 3'd2,
    OP_CLR_ALL  = 3'd3,
    OP_LIST     = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FILL,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic [15:0] key;
    logic [15:0] value;
  } entry_t;

  typedef struct packed {
    logic   shift;
    entry_t wb;
  } ring_ctl_t;

  typedef struct packed {
    logic [15:0] out_key_id;
    logic [15:0] out_loco_id;
    logic        status;
    logic        last;
  } rsp_t;

  // Magnitude as 17 bits so that the most negative value has its own code.
  function automatic logic [16:0] mag17(input logic [15:0] v);
    logic [16:0] ext;
    ext = {v[15], v};
    return ext[16] ? (~ext + 17'd1) : ext;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/ist_req_if.sv =====
// Request channel: operation, key and value with valid/ready.
`default_nettype none

interface ist_req_if;
  logic               valid;
  logic               ready;
  logic [2:0]         operation;
  logic signed [15:0] key_id;
  logic signed [15:0] loco_id;

  modport source (output valid, output operation, output key_id, output loco_id,
                  input ready);
  modport sink   (input valid, input operation, input key_id, input loco_id,
                  output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/ist_rsp_if.sv =====
// Response channel: reported key, value, status and last with valid/ready.
`default_nettype none

interface ist_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] out_key_id;
  logic signed [15:0] out_loco_id;
  logic               status;
  logic               last;

  modport source (output valid, output out_key_id, output out_loco_id,
                  output status, output last, input ready);
  modport sink   (input valid, input out_key_id, input out_loco_id,
                  input status, input last, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/ist_cell.sv =====
// One slot of the rotating entry ring.
`default_nettype none

module ist_cell (
  input  wire logic           clk,
  input  wire logic           shift,
  input  wire ist_pkg::entry_t d,
  output      ist_pkg::entry_t q
);
  import ist_pkg::*;

  entry_t entry;

  always_ff @(posedge clk) begin
    if (shift) begin
      entry <= d;
    end
  end

  assign q = entry;

endmodule

`default_nettype wire

// ===== hw/rtl/ist_ctrl.sv =====
// Sequencer: walks the ring, editing its head, one slot per cycle unless rsp stalls.
`default_nettype none

module ist_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  ist_req_if.sink                req,
  ist_rsp_if.source              rsp,
  input  wire ist_pkg::entry_t   head,
  output      ist_pkg::ring_ctl_t ring
);
  import ist_pkg::*;

  state_t            state, state_next;
  logic [IDX_W-1:0]  step, step_next;
  logic [2:0]        op, op_next;
  logic [15:0]       key, key_next;
  logic [15:0]       val, val_next;
  logic              found, found_next;
  logic [15:0]       fval, fval_next;
  logic              empty_ok, empty_ok_next;
  logic [IDX_W-1:0]  empty_idx, empty_idx_next;
  logic [IDX_W-1:0]  target, target_next;
  logic              grow, grow_next;
  logic              full, full_next;
  entry_t            pend, pend_next;
  logic              pend_ok, pend_ok_next;
  logic [NUM_W-1:0]  n, n_next;
  logic [CNT_W-1:0]  slots_used, slots_used_next;

  rsp_t              rsp_q;
  logic              rsp_valid;
  logic              out_load;
  rsp_t              out_data;
  logic              out_free;

  logic [IDX_W-1:0]  head_idx;
  logic              used;
  logic              key_hit;
  logic              go;

  // Slot DEPTH-1 reaches the head first, so the walk runs newest slot first.
  assign head_idx = IDX_W'(DEPTH - 1) - step;
  assign used     = CNT_W'(head_idx) < slots_used;
  assign key_hit  = head.key == key;
  assign out_free = !rsp_valid || rsp.ready;
  assign req.ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      step       <= '0;
      slots_used <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      step       <= step_next;
      slots_used <= slots_used_next;
      if (out_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    op        <= op_next;
    key       <= key_next;
    val       <= val_next;
    found     <= found_next;
    fval      <= fval_next;
    empty_ok  <= empty_ok_next;
    empty_idx <= empty_idx_next;
    target    <= target_next;
    grow      <= grow_next;
    full      <= full_next;
    pend      <= pend_next;
    pend_ok   <= pend_ok_next;
    n         <= n_next;
    if (out_load) begin
      rsp_q <= out_data;
    end
  end

  always_comb begin
    state_next      = state;
    step_next       = step;
    op_next         = op;
    key_next        = key;
    val_next        = val;
    found_next      = found;
    fval_next       = fval;
    empty_ok_next   = empty_ok;
    empty_idx_next  = empty_idx;
    target_next     = target;
    grow_next       = grow;
    full_next       = full;
    pend_next       = pend;
    pend_ok_next    = pend_ok;
    n_next          = n;
    slots_used_next = slots_used;
    ring.shift      = 1'b0;
    ring.wb         = head;
    out_load        = 1'b0;
    out_data        = '0;
    go              = 1'b1;

    unique case (state)
      ST_IDLE: begin
        if (req.valid) begin
          op_next       = req.operation;
          key_next      = req.key_id;
          val_next      = req.loco_id;
          found_next    = 1'b0;
          empty_ok_next = 1'b0;
          grow_next     = 1'b0;
          full_next     = 1'b0;
          pend_ok_next  = 1'b0;
          n_next        = '0;
          step_next     = '0;
          // Unknown operations are taken and dropped without a response.
          if (req.operation <= OP_LIST) begin
            state_next = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        unique case (op)
          OP_SET: begin
            if (used && !found && key_hit) begin
              ring.wb.value = val;
              if (val == 16'd0) begin
                ring.wb.key = 16'd0;
              end
              found_next = 1'b1;
            end
            if (used && !empty_ok && head.value == 16'd0) begin
              empty_ok_next  = 1'b1;
              empty_idx_next = head_idx;
            end
          end
          OP_GET: begin
            if (used && !found && key_hit) begin
              found_next = 1'b1;
              fval_next  = head.value;
            end
          end
          OP_CLR_LOCO: begin
            if (used && mag17(head.value) == mag17(val)) begin
              ring.wb = '0;
            end
          end
          OP_CLR_ALL: begin
            if (used) begin
              ring.wb = '0;
            end
          end
          OP_LIST: begin
            if (used && head.value != 16'd0 && (key == 16'd0 || key_hit) &&
                n < NUM_W'(MAX_RESULTS)) begin
              // The held match goes out only once a later one proves it is not last.
              if (pend_ok) begin
                if (out_free) begin
                  out_load = 1'b1;
                  out_data = '{out_key_id: pend.key, out_loco_id: pend.value,
                               status: 1'b0, last: 1'b0};
                end else begin
                  go = 1'b0;
                end
              end
              if (go) begin
                pend_next    = head;
                pend_ok_next = 1'b1;
                n_next       = n + NUM_W'(1);
              end
            end
          end
          default: ;
        endcase

        if (go) begin
          ring.shift = 1'b1;
          step_next  = step + IDX_W'(1);
          if (step == IDX_W'(DEPTH - 1)) begin
            step_next  = '0;
            state_next = ST_RESP;
            if (op == OP_SET && !found_next && val != 16'd0) begin
              if (empty_ok_next) begin
                target_next = empty_idx_next;
                state_next  = ST_FILL;
              end else if (slots_used < CNT_W'(DEPTH)) begin
                target_next = IDX_W'(slots_used);
                grow_next   = 1'b1;
                state_next  = ST_FILL;
              end else begin
                full_next = 1'b1;
              end
            end
          end
        end
      end

      ST_FILL: begin
        ring.shift = 1'b1;
        if (head_idx == target) begin
          ring.wb.key   = key;
          ring.wb.value = val;
        end
        step_next = step + IDX_W'(1);
        if (step == IDX_W'(DEPTH - 1)) begin
          step_next  = '0;
          state_next = ST_RESP;
          if (grow) begin
            slots_used_next = slots_used + CNT_W'(1);
          end
        end
      end

      ST_RESP: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
          unique case (op)
            OP_SET:      out_data = '{out_key_id: key, out_loco_id: val,
                                      status: full, last: 1'b1};
            OP_GET:      out_data = '{out_key_id: key,
                                      out_loco_id: found ? fval : 16'd0,
                                      status: 1'b0, last: 1'b1};
            OP_CLR_LOCO: out_data = '{out_key_id: 16'd0, out_loco_id: val,
                                      status: 1'b0, last: 1'b1};
            OP_LIST: begin
              if (pend_ok) begin
                out_data = '{out_key_id: pend.key, out_loco_id: pend.value,
                             status: 1'b0, last: 1'b1};
              end else begin
                out_data = '{out_key_id: key, out_loco_id: 16'd0,
                             status: 1'b0, last: 1'b1};
              end
            end
            default:     out_data = '{out_key_id: 16'd0, out_loco_id: 16'd0,
                                      status: 1'b0, last: 1'b1};
          endcase
        end
      end

      default: state_next = ST_IDLE;
    endcase
  end

  assign rsp.valid       = rsp_valid;
  assign rsp.out_key_id  = rsp_q.out_key_id;
  assign rsp.out_loco_id = rsp_q.out_loco_id;
  assign rsp.status      = rsp_q.status;
  assign rsp.last        = rsp_q.last;

  a_slots_bound: assert property (@(posedge clk) disable iff (rst)
    slots_used <= CNT_W'(DEPTH))
    else $error("slot count beyond table depth");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_load |-> out_free)
    else $error("response register loaded while still occupied");

  a_idle_step: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> step == '0)
    else $error("walk position not rewound at idle");

  a_start: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready && req.operation <= OP_LIST) |=> state == ST_SCAN)
    else $error("accepted request did not start a walk");

  a_list_cap: assert property (@(posedge clk) disable iff (rst)
    state != ST_IDLE |-> n <= NUM_W'(MAX_RESULTS))
    else $error("list match count beyond result limit");

endmodule

`default_nettype wire

// ===== hw/rtl/id_stash_table_core.sv =====
// Top level of the stash table: ring of entry cells and its sequencer.
//
//   channel  direction  fields
//   req      in         operation, key_id, loco_id
//   rsp      out        out_key_id, out_loco_id, status, last
//
// Every known operation walks the whole ring once, one slot reaching the head per cycle
// unless a list match waits on rsp; a set that must allocate walks it a second time to write.
// The request is taken before the walk and the final response is posted after it, waiting
// while rsp stalls; an unknown operation is taken and posts nothing. Requests wait until
// the previous last response is registered.
// Reset clears the slot count and the control state; entries are undefined until written.
`default_nettype none

module id_stash_table_core (
  input  wire logic clk,
  input  wire logic rst,
  ist_req_if.sink   req,
  ist_rsp_if.source rsp
);
  import ist_pkg::*;

  entry_t    cell_q [DEPTH];
  ring_ctl_t ring;

  ist_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .rsp  (rsp),
    .head (cell_q[DEPTH-1]),
    .ring (ring)
  );

  // Each cell passes its entry up one place per shift; the head wraps to cell 0.
  for (genvar j = 0; j < DEPTH; j++) begin : g_cell
    if (j == 0) begin : g_first
      ist_cell u_cell (
        .clk   (clk),
        .shift (ring.shift),
        .d     (ring.wb),
        .q     (cell_q[j])
      );
    end else begin : g_rest
      ist_cell u_cell (
        .clk   (clk),
        .shift (ring.shift),
        .d     (cell_q[j-1]),
        .q     (cell_q[j])
      );
    end
  end

endmodule

`default_nettype wire
